// ===== src/dbca_pkg.sv =====
`timescale 1ns / 1ps
package dbca_pkg;

  localparam int MAP_WORDS_DEF = 1024;
  localparam int WORD_W        = 64;
  localparam int CLUSTER_W     = 16;
  localparam int CFG_W         = 11;
  localparam int BIT_W         = 6;
  localparam int FIELD_WORDS   = 1024;
  localparam int WIDX_W        = 10;
  localparam logic [CFG_W-1:0] WORDS_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ACT_MARK_USED = 2'd0,
    ACT_MARK_FREE = 2'd1,
    ACT_QUERY     = 2'd2,
    ACT_FIND      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_FIND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic alloc_we;
    logic struct_we;
  } mem_we_t;

  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x;
    logic [BIT_W-1:0]  pos;
    x   = ~v;
    pos = '0;
    for (int i = BIT_W - 1; i >= 0; i--) begin
      if ((x & ((64'd1 << (1 << i)) - 64'd1)) == '0) begin
        pos[i] = 1'b1;
        x      = x >> (1 << i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== src/dbca_ram.sv =====
`timescale 1ns / 1ps
module dbca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/dbca_engine.sv =====
`timescale 1ns / 1ps
module dbca_engine #(
  parameter int MAP_WORDS = dbca_pkg::MAP_WORDS_DEF,
  parameter int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic                            in_which_map,
  input  logic                            in_also_structure,
  input  logic [dbca_pkg::CLUSTER_W-1:0]  in_cluster_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_bit_used,
  output logic                            out_free_found,
  output logic [dbca_pkg::CLUSTER_W-1:0]  out_free_cluster,
  input  logic [dbca_pkg::CFG_W-1:0]      words_in_use,
  output logic [AW-1:0]                   mem_addr,
  output dbca_pkg::mem_we_t               mem_we,
  output logic [dbca_pkg::WORD_W-1:0]     alloc_wdata,
  output logic [dbca_pkg::WORD_W-1:0]     struct_wdata,
  input  logic [dbca_pkg::WORD_W-1:0]     alloc_rdata,
  input  logic [dbca_pkg::WORD_W-1:0]     struct_rdata
);
  import dbca_pkg::*;

  localparam int WLIM = (MAP_WORDS < FIELD_WORDS) ? MAP_WORDS : FIELD_WORDS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  state_t                state_r, state_nxt;
  action_t               act_r;
  logic                  sel_r, mirror_r, in_map_r;
  logic [AW-1:0]         word_r;
  logic [BIT_W-1:0]      bit_r;
  logic [WIDX_W-1:0]     w_r, w_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic                  res_used_r, res_found_r;
  logic [CLUSTER_W-1:0]  res_cluster_r;
  logic                  out_valid_r, out_used_r, out_found_r;
  logic [CLUSTER_W-1:0]  out_cluster_r;

  logic                  accept, out_free, fin, f_used, f_found;
  logic [CLUSTER_W-1:0]  f_cluster;
  logic [CFG_W-1:0]      limit, w_inc;
  logic [15:0]           in_word16, w16;
  logic                  in_map;
  logic [WORD_W-1:0]     sel_word, mask;
  logic                  freeing;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign limit     = (words_in_use < CFG_W'(WLIM)) ? words_in_use : CFG_W'(WLIM);
  assign in_word16 = {6'b0, in_cluster_index[CLUSTER_W-1:BIT_W]};
  assign in_map    = {1'b0, in_word16} < 17'(MAP_WORDS);
  assign w_inc     = {1'b0, w_r} + 11'd1;
  assign w16       = {6'b0, w_inc[WIDX_W-1:0]};
  assign sel_word  = sel_r ? struct_rdata : alloc_rdata;
  assign mask      = 64'd1 << bit_r;
  assign freeing   = (act_r == ACT_MARK_FREE);

  always_comb begin
    state_nxt    = state_r;
    mem_addr     = word_r;
    mem_we       = '0;
    alloc_wdata  = freeing ? (alloc_rdata & ~mask) : (alloc_rdata | mask);
    struct_wdata = freeing ? (struct_rdata & ~mask) : (struct_rdata | mask);
    w_nxt        = w_r;
    clr_nxt      = clr_r;
    fin          = 1'b0;
    f_used       = 1'b0;
    f_found      = 1'b0;
    f_cluster    = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_addr         = clr_r;
        mem_we.alloc_we  = 1'b1;
        mem_we.struct_we = 1'b1;
        alloc_wdata      = '0;
        struct_wdata     = '0;
        clr_nxt          = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_addr = in_word16[AW-1:0];
        if (accept) begin
          if (action_t'(in_action) == ACT_FIND && limit != '0) begin
            mem_addr  = '0;
            w_nxt     = '0;
            state_nxt = ST_FIND;
          end else begin
            state_nxt = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        if ((act_r == ACT_MARK_USED || act_r == ACT_MARK_FREE) && in_map_r) begin
          mem_we.alloc_we  = 1'b1;
          mem_we.struct_we = mirror_r;
        end
        fin    = 1'b1;
        f_used = (act_r == ACT_QUERY) && in_map_r && sel_word[bit_r];
      end
      ST_FIND: begin
        if (sel_word != '1) begin
          fin       = 1'b1;
          f_found   = 1'b1;
          f_cluster = {w_r, lowest_zero(sel_word)};
        end else if (w_inc < limit) begin
          w_nxt    = w_inc[WIDX_W-1:0];
          mem_addr = w16[AW-1:0];
        end else begin
          fin = 1'b1;
        end
      end
      ST_DONE: begin
        fin       = 1'b1;
        f_used    = res_used_r;
        f_found   = res_found_r;
        f_cluster = res_cluster_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = out_free ? ST_IDLE : ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (fin && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (accept) begin
      act_r    <= action_t'(in_action);
      sel_r    <= in_which_map;
      mirror_r <= in_also_structure;
      word_r   <= in_word16[AW-1:0];
      bit_r    <= in_cluster_index[BIT_W-1:0];
      in_map_r <= in_map;
    end
    if (fin) begin
      if (out_free) begin
        out_used_r    <= f_used;
        out_found_r   <= f_found;
        out_cluster_r <= f_cluster;
      end else begin
        res_used_r    <= f_used;
        res_found_r   <= f_found;
        res_cluster_r <= f_cluster;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bit_used     = out_used_r;
  assign out_free_found   = out_found_r;
  assign out_free_cluster = out_cluster_r;

endmodule

// ===== src/dual_bitmap_cluster_allocator.sv =====
`timescale 1ns / 1ps
// Mark and query read the addressed word; a mark writes it back in the access state, a query does not.
// Find reads words from word 0 on until a non-full word or the words_in_use limit (at most MAP_WORDS).
// Throughput: one item at a time; the next transfer follows the result into the output register.
// Reset (rst_n low, synchronous) sets words_in_use to 1024 and starts a clearing pass that zeroes
// both maps one word a cycle, all MAP_WORDS words, with in_stall held high until it ends.
module dual_bitmap_cluster_allocator #(
  parameter int MAP_WORDS = dbca_pkg::MAP_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic                            in_which_map,
  input  logic                            in_also_structure,
  input  logic [dbca_pkg::CLUSTER_W-1:0]  in_cluster_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_bit_used,
  output logic                            out_free_found,
  output logic [dbca_pkg::CLUSTER_W-1:0]  out_free_cluster,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dbca_pkg::CFG_W-1:0]      cfg_data
);
  import dbca_pkg::*;

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [CFG_W-1:0]  words_in_use_r;
  logic [AW-1:0]     mem_addr;
  mem_we_t           mem_we;
  logic [WORD_W-1:0] alloc_wdata, struct_wdata, alloc_rdata, struct_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_in_use_r <= WORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      words_in_use_r <= cfg_data;
    end
  end

  dbca_engine #(
    .MAP_WORDS (MAP_WORDS),
    .AW        (AW)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_which_map      (in_which_map),
    .in_also_structure (in_also_structure),
    .in_cluster_index  (in_cluster_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bit_used      (out_bit_used),
    .out_free_found    (out_free_found),
    .out_free_cluster  (out_free_cluster),
    .words_in_use      (words_in_use_r),
    .mem_addr          (mem_addr),
    .mem_we            (mem_we),
    .alloc_wdata       (alloc_wdata),
    .struct_wdata      (struct_wdata),
    .alloc_rdata       (alloc_rdata),
    .struct_rdata      (struct_rdata)
  );

  dbca_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_alloc_ram (
    .clk   (clk),
    .we    (mem_we.alloc_we),
    .addr  (mem_addr),
    .wdata (alloc_wdata),
    .rdata (alloc_rdata)
  );

  dbca_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_struct_ram (
    .clk   (clk),
    .we    (mem_we.struct_we),
    .addr  (mem_addr),
    .wdata (struct_wdata),
    .rdata (struct_rdata)
  );

endmodule
